[hw/rtl/crc16fpr_pkg.sv]
// crc16fpr_pkg: shared types, codes and the crc byte update for the framed packet receiver
// no dependencies; used by every file under hw/rtl
package crc16fpr_pkg;

    localparam int COUNTER_WIDTH = 16;
    localparam int OUT_CNT_W     = 16;

    typedef logic [COUNTER_WIDTH-1:0] cnt_t;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_FIRST_HEADER  = 1'b0,
        REG_SECOND_HEADER = 1'b1
    } reg_index_t;

    // error counter slots
    typedef enum logic [1:0] {
        CNT_HEADER1_MISS = 2'd0,
        CNT_HEADER2_MISS = 2'd1,
        CNT_EMPTY_FRAME  = 2'd2,
        CNT_CRC_ERROR    = 2'd3
    } cnt_sel_t;

    typedef enum logic [2:0] {
        PH_H1   = 3'd0,
        PH_H2   = 3'd1,
        PH_LEN  = 3'd2,
        PH_ID   = 3'd3,
        PH_PAY  = 3'd4,
        PH_CRCL = 3'd5,
        PH_CRCH = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE         = 3'd0,
        EV_PAYLOAD      = 3'd1,
        EV_FRAME_GOOD   = 3'd2,
        EV_CRC_MISMATCH = 3'd3,
        EV_HEADER1_MISS = 3'd4,
        EV_HEADER2_MISS = 3'd5,
        EV_ZERO_LENGTH  = 3'd6
    } event_t;

    typedef struct packed {
        event_t               event_res;
        logic [7:0]           payload_byte;
        logic [7:0]           payload_index;
        logic [7:0]           message_id;
        logic [7:0]           frame_length;
        logic [15:0]          computed_crc;
        logic [15:0]          received_crc;
        logic [OUT_CNT_W-1:0] header1_miss_count;
        logic [OUT_CNT_W-1:0] header2_miss_count;
        logic [OUT_CNT_W-1:0] empty_frame_count;
        logic [OUT_CNT_W-1:0] crc_error_count;
    } result_t;

    // reflected ccitt byte update, poly 0x8408
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] d;
        d = b ^ crc[7:0];
        d = d ^ {d[3:0], 4'b0000};
        return {d, crc[15:8]} ^ {12'h000, d[7:4]} ^ {5'b00000, d, 3'b000};
    endfunction

endpackage

[hw/rtl/crc16fpr_if.sv]
// crc16fpr byte and result channel interfaces, valid/ready handshake
// depends on crc16fpr_pkg for the counter width
interface crc16fpr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface crc16fpr_res_if;
    logic                              valid;
    logic                              ready;
    logic [2:0]                        event_res;
    logic [7:0]                        payload_byte;
    logic [7:0]                        payload_index;
    logic [7:0]                        message_id;
    logic [7:0]                        frame_length;
    logic [15:0]                       computed_crc;
    logic [15:0]                       received_crc;
    logic [crc16fpr_pkg::OUT_CNT_W-1:0] header1_miss_count;
    logic [crc16fpr_pkg::OUT_CNT_W-1:0] header2_miss_count;
    logic [crc16fpr_pkg::OUT_CNT_W-1:0] empty_frame_count;
    logic [crc16fpr_pkg::OUT_CNT_W-1:0] crc_error_count;

    modport source (
        output valid, output event_res, output payload_byte, output payload_index,
        output message_id, output frame_length, output computed_crc, output received_crc,
        output header1_miss_count, output header2_miss_count, output empty_frame_count,
        output crc_error_count, input ready
    );
    modport sink (
        input valid, input event_res, input payload_byte, input payload_index,
        input message_id, input frame_length, input computed_crc, input received_crc,
        input header1_miss_count, input header2_miss_count, input empty_frame_count,
        input crc_error_count, output ready
    );
endinterface

[hw/rtl/crc16_framed_packet_receiver.sv]
// crc16_framed_packet_receiver: one result word out for every byte taken in
// the result is registered and appears in the cycle after the byte is accepted
// throughput: one byte per cycle while the single result register is not stalled
// reset: frame hunt restarts at header 1, crc, counters and header registers clear
// depends on crc16fpr_pkg, crc16fpr_if, crc16fpr_core, crc16fpr_outreg
module crc16_framed_packet_receiver (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    crc16fpr_byte_if.sink        byte_ch,
    crc16fpr_res_if.source       result_ch
);

    crc16fpr_pkg::result_t core_res;
    crc16fpr_pkg::result_t out_res;
    logic                  up_ready;
    logic                  take;

    assign byte_ch.ready = up_ready;
    assign take          = byte_ch.valid && up_ready;

    crc16fpr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .data_byte (byte_ch.data_byte),
        .result    (core_res)
    );

    crc16fpr_outreg u_outreg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (take),
        .result_in  (core_res),
        .down_ready (result_ch.ready),
        .up_ready   (up_ready),
        .valid      (result_ch.valid),
        .result_out (out_res)
    );

    assign result_ch.event_res          = out_res.event_res;
    assign result_ch.payload_byte       = out_res.payload_byte;
    assign result_ch.payload_index      = out_res.payload_index;
    assign result_ch.message_id         = out_res.message_id;
    assign result_ch.frame_length       = out_res.frame_length;
    assign result_ch.computed_crc       = out_res.computed_crc;
    assign result_ch.received_crc       = out_res.received_crc;
    assign result_ch.header1_miss_count = out_res.header1_miss_count;
    assign result_ch.header2_miss_count = out_res.header2_miss_count;
    assign result_ch.empty_frame_count  = out_res.empty_frame_count;
    assign result_ch.crc_error_count    = out_res.crc_error_count;

endmodule

[hw/rtl/crc16fpr_core.sv]
// crc16fpr_core: frame phase tracking, running crc, error counters and header registers
// depends on crc16fpr_pkg
module crc16fpr_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_index,
    input  logic [7:0]            cfg_data,
    input  logic                  take,
    input  logic [7:0]            data_byte,
    output crc16fpr_pkg::result_t result
);

    logic [7:0]                 hdr1_reg;
    logic [7:0]                 hdr2_reg;
    crc16fpr_pkg::phase_t       phase_reg, phase_next;
    logic [7:0]                 length_reg, length_next;
    logic [7:0]                 taken_reg, taken_next;
    logic [7:0]                 id_reg, id_next;
    logic [15:0]                crc_reg, crc_next;
    logic [7:0]                 crc_low_reg, crc_low_next;
    crc16fpr_pkg::cnt_t         cnt_reg [4];
    crc16fpr_pkg::cnt_t         cnt_next [4];
    logic [3:0]                 bump;
    crc16fpr_pkg::event_t       ev;
    logic [7:0]                 pay_byte;
    logic [7:0]                 pay_index;
    logic [15:0]                rx_crc;
    logic [15:0]                rx_word;

    assign rx_word = {data_byte, crc_low_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr1_reg <= 8'h00;
            hdr2_reg <= 8'h00;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                crc16fpr_pkg::REG_FIRST_HEADER:  hdr1_reg <= cfg_data;
                crc16fpr_pkg::REG_SECOND_HEADER: hdr2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // next state of the frame tracker
    always_comb
    begin
        phase_next   = phase_reg;
        length_next  = length_reg;
        taken_next   = taken_reg;
        id_next      = id_reg;
        crc_next     = crc_reg;
        crc_low_next = crc_low_reg;
        bump         = 4'b0000;
        ev           = crc16fpr_pkg::EV_NONE;
        pay_byte     = 8'h00;
        pay_index    = 8'h00;
        rx_crc       = 16'h0000;
        case (phase_reg)
            crc16fpr_pkg::PH_H2:
            begin
                if (data_byte == hdr2_reg)
                begin
                    phase_next = crc16fpr_pkg::PH_LEN;
                end
                else
                begin
                    bump[crc16fpr_pkg::CNT_HEADER2_MISS] = 1'b1;
                    ev         = crc16fpr_pkg::EV_HEADER2_MISS;
                    phase_next = crc16fpr_pkg::PH_H1;
                end
            end
            crc16fpr_pkg::PH_LEN:
            begin
                if (data_byte != 8'h00)
                begin
                    length_next = data_byte;
                    phase_next  = crc16fpr_pkg::PH_ID;
                end
                else
                begin
                    bump[crc16fpr_pkg::CNT_EMPTY_FRAME] = 1'b1;
                    ev         = crc16fpr_pkg::EV_ZERO_LENGTH;
                    phase_next = crc16fpr_pkg::PH_H1;
                end
            end
            crc16fpr_pkg::PH_ID:
            begin
                id_next    = data_byte;
                crc_next   = crc16fpr_pkg::crc_byte(16'h0000, data_byte);
                taken_next = 8'd1;
                // length of one has no payload
                phase_next = (length_reg == 8'd1) ? crc16fpr_pkg::PH_CRCL
                                                  : crc16fpr_pkg::PH_PAY;
            end
            crc16fpr_pkg::PH_PAY:
            begin
                ev         = crc16fpr_pkg::EV_PAYLOAD;
                pay_byte   = data_byte;
                pay_index  = taken_reg;
                crc_next   = crc16fpr_pkg::crc_byte(crc_reg, data_byte);
                taken_next = taken_reg + 8'd1;
                if (taken_next == length_reg)
                begin
                    phase_next = crc16fpr_pkg::PH_CRCL;
                end
            end
            crc16fpr_pkg::PH_CRCL:
            begin
                crc_low_next = data_byte;
                phase_next   = crc16fpr_pkg::PH_CRCH;
            end
            crc16fpr_pkg::PH_CRCH:
            begin
                rx_crc = rx_word;
                if (rx_word == crc_reg)
                begin
                    ev = crc16fpr_pkg::EV_FRAME_GOOD;
                end
                else
                begin
                    ev = crc16fpr_pkg::EV_CRC_MISMATCH;
                    bump[crc16fpr_pkg::CNT_CRC_ERROR] = 1'b1;
                end
                taken_next = 8'd1;
                phase_next = crc16fpr_pkg::PH_H1;
            end
            default:
            begin
                // unused code behaves as header 1 hunt
                if (data_byte == hdr1_reg)
                begin
                    phase_next = crc16fpr_pkg::PH_H2;
                end
                else
                begin
                    bump[crc16fpr_pkg::CNT_HEADER1_MISS] = 1'b1;
                    ev         = crc16fpr_pkg::EV_HEADER1_MISS;
                    phase_next = crc16fpr_pkg::PH_H1;
                end
            end
        endcase
    end

    // saturating counters
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            cnt_next[k] = cnt_reg[k];
            if (bump[k] && (cnt_reg[k] != '1))
            begin
                cnt_next[k] = cnt_reg[k] + crc16fpr_pkg::cnt_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= crc16fpr_pkg::PH_H1;
            length_reg  <= 8'h00;
            taken_reg   <= 8'd1;
            id_reg      <= 8'h00;
            crc_reg     <= 16'h0000;
            crc_low_reg <= 8'h00;
            for (int k = 0; k < 4; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else if (take)
        begin
            phase_reg   <= phase_next;
            length_reg  <= length_next;
            taken_reg   <= taken_next;
            id_reg      <= id_next;
            crc_reg     <= crc_next;
            crc_low_reg <= crc_low_next;
            for (int k = 0; k < 4; k++)
            begin
                cnt_reg[k] <= cnt_next[k];
            end
        end
    end

    always_comb
    begin
        result.event_res          = ev;
        result.payload_byte       = pay_byte;
        result.payload_index      = pay_index;
        result.message_id         = id_next;
        result.frame_length       = length_next;
        result.computed_crc       = crc_next;
        result.received_crc       = rx_crc;
        result.header1_miss_count =
            crc16fpr_pkg::OUT_CNT_W'(cnt_next[crc16fpr_pkg::CNT_HEADER1_MISS]);
        result.header2_miss_count =
            crc16fpr_pkg::OUT_CNT_W'(cnt_next[crc16fpr_pkg::CNT_HEADER2_MISS]);
        result.empty_frame_count  =
            crc16fpr_pkg::OUT_CNT_W'(cnt_next[crc16fpr_pkg::CNT_EMPTY_FRAME]);
        result.crc_error_count    =
            crc16fpr_pkg::OUT_CNT_W'(cnt_next[crc16fpr_pkg::CNT_CRC_ERROR]);
    end

endmodule

[hw/rtl/crc16fpr_outreg.sv]
// crc16fpr_outreg: result register between the frame tracker and the output channel
// depends on crc16fpr_pkg
module crc16fpr_outreg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  crc16fpr_pkg::result_t result_in,
    input  logic                  down_ready,
    output logic                  up_ready,
    output logic                  valid,
    output crc16fpr_pkg::result_t result_out
);

    logic                  valid_reg;
    crc16fpr_pkg::result_t data_reg;

    // a new word may enter whenever the register is empty or the held one leaves this cycle
    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result_in;
        end
    end

    assign valid      = valid_reg;
    assign result_out = data_reg;

endmodule

[dv/crc16fpr_checker.sv]
// crc16fpr_checker: watches the byte and result channels, predicts each result word
// depends on crc16fpr_pkg and the channel interfaces in crc16fpr_if
`timescale 1ns / 100ps

module crc16fpr_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [0:0]     cfg_index,
    input  logic [7:0]     cfg_data,
    crc16fpr_byte_if       byte_mon,
    crc16fpr_res_if        res_mon,
    output int             fail_count,
    output int             pending
);

    // mirrored header registers and frame state
    logic [7:0]           hdr1;
    logic [7:0]           hdr2;
    crc16fpr_pkg::phase_t rx_phase;
    logic [7:0]           len_seen;
    logic [7:0]           taken;
    logic [7:0]           cur_id;
    logic [15:0]          crc_acc;
    logic [7:0]           crc_lo;
    crc16fpr_pkg::cnt_t   err_cnt [4];

    crc16fpr_pkg::result_t parsed_q [$];

    // bitwise reflected update, poly 0x8408
    function automatic logic [15:0] kermit_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
        return c;
    endfunction

    task automatic bump(input crc16fpr_pkg::cnt_sel_t k);
        if (err_cnt[k] != '1)
            err_cnt[k] = err_cnt[k] + crc16fpr_pkg::cnt_t'(1);
    endtask

    task automatic parse_rx_byte(input logic [7:0] b, output crc16fpr_pkg::result_t r);
        crc16fpr_pkg::event_t ev;
        logic [7:0]           pb;
        logic [7:0]           pi;
        logic [15:0]          rx;
        ev = crc16fpr_pkg::EV_NONE;
        pb = 8'h00;
        pi = 8'h00;
        rx = 16'h0000;
        case (rx_phase)
            crc16fpr_pkg::PH_H2:
                if (b == hdr2)
                    rx_phase = crc16fpr_pkg::PH_LEN;
                else
                begin
                    bump(crc16fpr_pkg::CNT_HEADER2_MISS);
                    ev = crc16fpr_pkg::EV_HEADER2_MISS;
                    rx_phase = crc16fpr_pkg::PH_H1;
                end
            crc16fpr_pkg::PH_LEN:
                if (b != 8'h00)
                begin
                    len_seen = b;
                    rx_phase = crc16fpr_pkg::PH_ID;
                end
                else
                begin
                    bump(crc16fpr_pkg::CNT_EMPTY_FRAME);
                    ev = crc16fpr_pkg::EV_ZERO_LENGTH;
                    rx_phase = crc16fpr_pkg::PH_H1;
                end
            crc16fpr_pkg::PH_ID:
            begin
                cur_id = b;
                crc_acc = kermit_update(16'h0000, b);
                taken = 8'd1;
                // length of one has no payload, next byte is the crc low byte
                rx_phase = (len_seen == 8'd1) ? crc16fpr_pkg::PH_CRCL : crc16fpr_pkg::PH_PAY;
            end
            crc16fpr_pkg::PH_PAY:
            begin
                ev = crc16fpr_pkg::EV_PAYLOAD;
                pb = b;
                pi = taken;
                crc_acc = kermit_update(crc_acc, b);
                taken = taken + 8'd1;
                if (taken == len_seen)
                    rx_phase = crc16fpr_pkg::PH_CRCL;
            end
            crc16fpr_pkg::PH_CRCL:
            begin
                crc_lo = b;
                rx_phase = crc16fpr_pkg::PH_CRCH;
            end
            crc16fpr_pkg::PH_CRCH:
            begin
                rx = {b, crc_lo};
                if (rx == crc_acc)
                    ev = crc16fpr_pkg::EV_FRAME_GOOD;
                else
                begin
                    ev = crc16fpr_pkg::EV_CRC_MISMATCH;
                    bump(crc16fpr_pkg::CNT_CRC_ERROR);
                end
                taken = 8'd1;
                rx_phase = crc16fpr_pkg::PH_H1;
            end
            default:
                // header hunt, also covers the unused phase code
                if (b == hdr1)
                    rx_phase = crc16fpr_pkg::PH_H2;
                else
                begin
                    bump(crc16fpr_pkg::CNT_HEADER1_MISS);
                    ev = crc16fpr_pkg::EV_HEADER1_MISS;
                    rx_phase = crc16fpr_pkg::PH_H1;
                end
        endcase
        r.event_res          = ev;
        r.payload_byte       = pb;
        r.payload_index      = pi;
        r.message_id         = cur_id;
        r.frame_length       = len_seen;
        r.computed_crc       = crc_acc;
        r.received_crc       = rx;
        r.header1_miss_count =
            crc16fpr_pkg::OUT_CNT_W'(err_cnt[crc16fpr_pkg::CNT_HEADER1_MISS]);
        r.header2_miss_count =
            crc16fpr_pkg::OUT_CNT_W'(err_cnt[crc16fpr_pkg::CNT_HEADER2_MISS]);
        r.empty_frame_count  =
            crc16fpr_pkg::OUT_CNT_W'(err_cnt[crc16fpr_pkg::CNT_EMPTY_FRAME]);
        r.crc_error_count    =
            crc16fpr_pkg::OUT_CNT_W'(err_cnt[crc16fpr_pkg::CNT_CRC_ERROR]);
    endtask

    task automatic cmp_field(input string fname, input logic [31:0] e, input logic [31:0] a);
        if (e !== a)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, e, a);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        crc16fpr_pkg::result_t exp_w;
        crc16fpr_pkg::result_t new_w;
        if (!rst_n)
        begin
            hdr1 = 8'h00;
            hdr2 = 8'h00;
            rx_phase = crc16fpr_pkg::PH_H1;
            len_seen = 8'h00;
            taken = 8'd1;
            cur_id = 8'h00;
            crc_acc = 16'h0000;
            crc_lo = 8'h00;
            for (int k = 0; k < 4; k++)
                err_cnt[k] = '0;
            parsed_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            // a result word always belongs to an earlier byte, so compare first
            if (res_mon.valid && res_mon.ready)
            begin
                if (parsed_q.size() == 0)
                begin
                    $display("%0t: result word with nothing expected, event %0h",
                             $time, res_mon.event_res);
                    fail_count++;
                end
                else
                begin
                    exp_w = parsed_q.pop_front();
                    cmp_field("event_res", exp_w.event_res, res_mon.event_res);
                    cmp_field("payload_byte", exp_w.payload_byte, res_mon.payload_byte);
                    cmp_field("payload_index", exp_w.payload_index, res_mon.payload_index);
                    cmp_field("message_id", exp_w.message_id, res_mon.message_id);
                    cmp_field("frame_length", exp_w.frame_length, res_mon.frame_length);
                    cmp_field("computed_crc", exp_w.computed_crc, res_mon.computed_crc);
                    cmp_field("received_crc", exp_w.received_crc, res_mon.received_crc);
                    cmp_field("header1_miss_count", exp_w.header1_miss_count,
                              res_mon.header1_miss_count);
                    cmp_field("header2_miss_count", exp_w.header2_miss_count,
                              res_mon.header2_miss_count);
                    cmp_field("empty_frame_count", exp_w.empty_frame_count,
                              res_mon.empty_frame_count);
                    cmp_field("crc_error_count", exp_w.crc_error_count,
                              res_mon.crc_error_count);
                end
            end
            if (byte_mon.valid && byte_mon.ready)
            begin
                parse_rx_byte(byte_mon.data_byte, new_w);
                parsed_q.push_back(new_w);
            end
            if (cfg_we)
            begin
                case (crc16fpr_pkg::reg_index_t'(cfg_index))
                    crc16fpr_pkg::REG_FIRST_HEADER:  hdr1 = cfg_data;
                    crc16fpr_pkg::REG_SECOND_HEADER: hdr2 = cfg_data;
                    default: ;
                endcase
            end
            pending = parsed_q.size();
        end
    end

endmodule

[dv/tb_crc16_framed_packet_receiver.sv]
// tb_crc16_framed_packet_receiver: byte stream stimulus, header settings and verdict
// depends on crc16fpr_pkg, crc16fpr_if, the receiver rtl and crc16fpr_checker
`timescale 1ns / 100ps

module tb_crc16_framed_packet_receiver;

    localparam int WATCHDOG_LIMIT = 4000;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [0:0] cfg_index;
    logic [7:0] cfg_data;

    crc16fpr_byte_if byte_ch ();
    crc16fpr_res_if  result_ch ();

    int          checker_fails;
    int          checker_pending;
    int unsigned sent;
    int unsigned burst_left;
    int unsigned idle_cycles;
    logic [7:0]  cur_h1;
    logic [7:0]  cur_h2;

    crc16_framed_packet_receiver DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .byte_ch   (byte_ch),
        .result_ch (result_ch)
    );

    crc16fpr_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .byte_mon   (byte_ch),
        .res_mon    (result_ch),
        .fail_count (checker_fails),
        .pending    (checker_pending)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side stalls, pattern changes every stretch
    initial
    begin : result_stall
        int unsigned mode;
        int unsigned span;
        int unsigned tick;
        tick = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(32, 200);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0: result_ch.ready <= 1'b1;
                    1: result_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: result_ch.ready <= ((tick % 3) != 2);
                    default: result_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
                tick++;
            end
        end
    end

    function automatic logic [15:0] frame_crc(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
        return c;
    endfunction

    function automatic logic [7:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 199);
        if (r == 0)
            return 8'd255;
        else if (r < 3)
            return 8'($urandom_range(128, 254));
        else if (r < 20)
            return 8'($urandom_range(9, 40));
        return 8'($urandom_range(1, 8));
    endfunction

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
        end
        burst_left--;
        if (gap != 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= b;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic send_frame(input logic [7:0] len, input logic [7:0] id, input bit bad_crc);
        logic [15:0] crc;
        logic [7:0]  b;
        send_byte(cur_h1);
        send_byte(cur_h2);
        send_byte(len);
        send_byte(id);
        crc = frame_crc(16'h0000, id);
        for (int i = 1; i < int'(len); i++)
        begin
            b = 8'($urandom);
            crc = frame_crc(crc, b);
            send_byte(b);
        end
        if (bad_crc)
            crc = crc ^ 16'($urandom_range(1, 65535));
        send_byte(crc[7:0]);
        send_byte(crc[15:8]);
    endtask

    task automatic send_h2_miss();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == cur_h2);
        send_byte(cur_h1);
        send_byte(b);
    endtask

    task automatic send_empty_frame();
        send_byte(cur_h1);
        send_byte(cur_h2);
        send_byte(8'h00);
    endtask

    task automatic random_traffic(input int unsigned count);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned n;
        logic [7:0]  len;
        stop_at = sent + count;
        while (sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 68)
                send_frame(pick_length(), 8'($urandom), $urandom_range(0, 9) == 0);
            else if (pick < 80)
            begin
                n = $urandom_range(1, 6);
                repeat (n) send_byte(8'($urandom));
            end
            else if (pick < 88)
                send_h2_miss();
            else if (pick < 95)
                send_empty_frame();
            else if (pick < 98)
            begin
                // repeated header bytes
                send_byte(cur_h1);
                send_byte(cur_h1);
                send_byte(cur_h2);
            end
            else
            begin
                // frame cut short, the receiver swallows what follows as payload
                len = 8'($urandom_range(4, 20));
                send_byte(cur_h1);
                send_byte(cur_h2);
                send_byte(len);
                send_byte(8'($urandom));
                n = $urandom_range(0, int'(len) - 3);
                repeat (n) send_byte(8'($urandom));
            end
        end
    endtask

    task automatic drain();
        byte_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (checker_pending != 0);
        repeat (2) @(negedge clk);
    endtask

    task automatic set_headers(input logic [7:0] h1, input logic [7:0] h2);
        cfg_we <= 1'b1;
        cfg_index <= crc16fpr_pkg::REG_FIRST_HEADER;
        cfg_data <= h1;
        @(negedge clk);
        cfg_index <= crc16fpr_pkg::REG_SECOND_HEADER;
        cfg_data <= h2;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        cur_h1 = h1;
        cur_h2 = h2;
    endtask

    initial
    begin : stimulus
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = crc16fpr_pkg::REG_FIRST_HEADER;
        cfg_data = 8'h00;
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = 8'h00;
        sent = 0;
        burst_left = 0;
        cur_h1 = 8'h00;
        cur_h2 = 8'h00;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed, headers at their reset value
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h01);
        send_empty_frame();
        send_frame(8'd1, 8'hFF, 1'b0);
        send_frame(8'd2, 8'h00, 1'b0);
        send_frame(8'd1, 8'h80, 1'b1);

        drain();
        set_headers(8'hA5, 8'h5A);
        random_traffic(300);
        drain();
        set_headers(8'hFF, 8'hFF);
        send_frame(8'd255, 8'h5C, 1'b0);
        random_traffic(200);
        drain();
        set_headers(8'h00, 8'hFF);
        random_traffic(200);
        drain();
        set_headers(8'hFF, 8'h00);
        random_traffic(200);
        drain();
        set_headers(8'($urandom), 8'($urandom));
        random_traffic(200);
        drain();
        set_headers(8'hA5, 8'h5A);
        random_traffic(150);
        drain();
        repeat (4) @(negedge clk);

        if (checker_fails == 0 && checker_pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
